>>> rtl/rcpwc_pkg.sv
// Shared constants and types for the RC pulse width capture block.
package rcpwc_pkg;

	localparam int PIN_W    = 8;
	localparam int TIME_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int DUTY_W   = FRAC_W + 1;
	localparam int CFG_IDX_W = 2;

	localparam int NUM_CHANNELS_DEF = 4;

	localparam logic [PIN_W-1:0]  PIN_MASK_RST  = 8'd15;
	localparam logic [TIME_W-1:0] MAX_WIDTH_RST = 32'd125;
	localparam logic [TIME_W-1:0] MIN_WIDTH_RST = 32'd63;

	// Full scale duty, 1.0 in Q1.16
	localparam logic [DUTY_W-1:0] DUTY_FULL = 17'h10000;
	localparam logic [DUTY_W-1:0] DUTY_ZERO = 17'h00000;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PIN_MASK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 2'd2;

	// Divider request: remainder seed (below the span) and span
	typedef struct packed {
		logic              start;
		logic [TIME_W-1:0] numer;
		logic [TIME_W-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [FRAC_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> rtl/rcpwc_chan_map.sv
// Pin-to-channel selection: the first set mask bits, from bit 0 up, feed the channels.
module rcpwc_chan_map #(
	parameter int NumChannels = rcpwc_pkg::NUM_CHANNELS_DEF
) (
	input  logic [rcpwc_pkg::PIN_W-1:0] pin_mask,
	input  logic [rcpwc_pkg::PIN_W-1:0] pin_levels,
	output logic [NumChannels-1:0]      chan_levels
);

	localparam int CntW = $clog2(rcpwc_pkg::PIN_W + 1);

	logic [CntW-1:0] cnt;

	always_comb begin
		chan_levels = '0;
		cnt         = '0;
		for (int b = 0; b < rcpwc_pkg::PIN_W; b++) begin
			if (pin_mask[b]) begin
				for (int k = 0; k < NumChannels; k++) begin
					if (cnt == CntW'(k)) begin
						chan_levels[k] = pin_levels[b];
					end
				end
				cnt = cnt + 1'b1;
			end
		end
	end

endmodule

>>> rtl/rcpwc_divider.sv
// Shared restoring divider, one quotient bit per cycle, fraction bits only.
module rcpwc_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  rcpwc_pkg::div_req_t req,
	output rcpwc_pkg::div_rsp_t rsp
);

	localparam int TW   = rcpwc_pkg::TIME_W;
	localparam int FW   = rcpwc_pkg::FRAC_W;
	localparam int CntW = $clog2(FW);

	logic [TW-1:0]   rem_q;
	logic [TW-1:0]   span_q;
	logic [FW-1:0]   quo_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [TW:0] shifted;
	logic [TW:0] diff;
	logic        ge;

	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, span_q};
	assign ge      = shifted >= {1'b0, span_q};

	// remainder stays below the span, so it always fits TW bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.numer;
			span_q <= req.denom;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[TW-1:0] : shifted[TW-1:0];
			quo_q <= {quo_q[FW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(FW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> rtl/rc_pulse_width_capture.sv
// RC pulse width capture: edge detect, width measure, duty map on a shared divider.
// Sequence: an accepted item moves from IDLE to SCAN; each pending falling edge then runs
// SCAN, MAP, DIV when the width lies strictly between min and max, and OUT; with none left, IDLE.
// A new item is taken only in IDLE, after every result of the last one has been accepted;
// an output stall holds the sequencer in OUT, and the 16-step divider dominates.
// Reset: arst_n async active low; clears levels, sequencer and config to defaults.
module rc_pulse_width_capture #(
	parameter  int NumChannels = rcpwc_pkg::NUM_CHANNELS_DEF,
	localparam int ChanW       = (NumChannels > 1) ? $clog2(NumChannels) : 1,
	localparam int OutDw       = ((ChanW + rcpwc_pkg::TIME_W + rcpwc_pkg::DUTY_W + 7) / 8) * 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [7:0] pin_levels, [39:8] time_count
	input  logic [rcpwc_pkg::PIN_W+rcpwc_pkg::TIME_W-1:0] s_axis_tdata,
	// result stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// channel, pulse_width, duty from bit 0 up; zero padded to bytes
	output logic [OutDw-1:0]                      m_axis_tdata,
	output logic                                  m_axis_tlast,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [rcpwc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rcpwc_pkg::TIME_W-1:0]          cfg_wdata
);

	localparam int PW = rcpwc_pkg::PIN_W;
	localparam int TW = rcpwc_pkg::TIME_W;
	localparam int DW = rcpwc_pkg::DUTY_W;
	localparam int PadW = OutDw - ChanW - TW - DW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MAP,
		ST_DIV,
		ST_OUT
	} state_t;

	// Config registers
	logic [PW-1:0] pin_mask_q;
	logic [TW-1:0] max_width_q;
	logic [TW-1:0] min_width_q;

	// Channel state: last level per channel, start time per channel
	logic [NumChannels-1:0] prev_q;
	logic [TW-1:0]          start_q [NumChannels];

	// Pending falling edges of the current item, walked lowest first
	logic [NumChannels-1:0] fall_q;
	logic [TW-1:0]          now_q;

	state_t           state_q;
	logic [ChanW-1:0] chan_q;
	logic [TW-1:0]    width_q;
	logic [DW-1:0]    duty_q;

	logic [PW-1:0]          in_pins;
	logic [TW-1:0]          in_time;
	logic [NumChannels-1:0] chan_levels;
	logic                   in_xfer;
	logic                   out_xfer;

	logic             fall_hit;
	logic [ChanW-1:0] fall_idx;

	rcpwc_pkg::div_req_t div_req;
	rcpwc_pkg::div_rsp_t div_rsp;

	assign in_pins = s_axis_tdata[PW-1:0];
	assign in_time = s_axis_tdata[PW+TW-1:PW];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign out_xfer      = m_axis_tvalid && m_axis_tready;

	rcpwc_chan_map #(
		.NumChannels(NumChannels)
	) u_chan_map (
		.pin_mask   (pin_mask_q),
		.pin_levels (in_pins),
		.chan_levels(chan_levels)
	);

	rcpwc_divider u_divider (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Lowest pending falling edge
	always_comb begin
		fall_hit = 1'b0;
		fall_idx = '0;
		for (int k = NumChannels - 1; k >= 0; k--) begin
			if (fall_q[k]) begin
				fall_hit = 1'b1;
				fall_idx = ChanW'(k);
			end
		end
	end

	// Division only when min < width < max, so the seed is below the span
	always_comb begin
		div_req.start = (state_q == ST_MAP) && !(width_q >= max_width_q)
			&& !(width_q <= min_width_q);
		div_req.numer = width_q - min_width_q;
		div_req.denom = max_width_q - min_width_q;
	end

	// Config writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_mask_q  <= rcpwc_pkg::PIN_MASK_RST;
			max_width_q <= rcpwc_pkg::MAX_WIDTH_RST;
			min_width_q <= rcpwc_pkg::MIN_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rcpwc_pkg::REG_PIN_MASK:  pin_mask_q  <= cfg_wdata[PW-1:0];
				rcpwc_pkg::REG_MAX_WIDTH: max_width_q <= cfg_wdata;
				rcpwc_pkg::REG_MIN_WIDTH: min_width_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Start times: written on a rising edge, item time on every transfer; no reset (read only after a write)
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			now_q <= in_time;
			for (int k = 0; k < NumChannels; k++) begin
				if (!prev_q[k] && chan_levels[k]) begin
					start_q[k] <= in_time;
				end
			end
		end
	end

	// Sequencer with registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_q  <= '0;
			fall_q  <= '0;
			chan_q  <= '0;
			width_q <= '0;
			duty_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						for (int k = 0; k < NumChannels; k++) begin
							fall_q[k] <= prev_q[k] && !chan_levels[k];
						end
						prev_q  <= chan_levels;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (fall_hit) begin
						chan_q          <= fall_idx;
						width_q         <= now_q - start_q[fall_idx];
						fall_q[fall_idx] <= 1'b0;
						state_q         <= ST_MAP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MAP: begin
					// max test first: it wins when max is not above min
					if (width_q >= max_width_q) begin
						duty_q  <= rcpwc_pkg::DUTY_FULL;
						state_q <= ST_OUT;
					end else if (width_q <= min_width_q) begin
						duty_q  <= rcpwc_pkg::DUTY_ZERO;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						duty_q  <= {1'b0, div_rsp.quotient};
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_xfer) begin
						state_q <= fall_hit ? ST_SCAN : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Last result of the item once no falling edge is left pending
	assign m_axis_tlast = !fall_hit;
	assign m_axis_tdata = {{PadW{1'b0}}, duty_q, width_q, chan_q};

	// A result never overlaps an accepted input
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("result valid while input ready");

	// Duty never above full scale
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (duty_q <= rcpwc_pkg::DUTY_FULL))
		else $error("duty above full scale");

	// Divider finishes only while the sequencer waits on it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider done outside division state");

	// After the final result transfer the block takes input again
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && m_axis_tlast) |=> s_axis_tready)
		else $error("not ready after final result");

endmodule

>>> verif/tb.sv
// Testbench for rc_pulse_width_capture: pulse frames in, checked duty results out.
module tb;

	localparam int PIN_W     = rcpwc_pkg::PIN_W;
	localparam int TIME_W    = rcpwc_pkg::TIME_W;
	localparam int FRAC_W    = rcpwc_pkg::FRAC_W;
	localparam int DUTY_W    = rcpwc_pkg::DUTY_W;
	localparam int CFG_IDX_W = rcpwc_pkg::CFG_IDX_W;

	localparam int NUM_CH   = rcpwc_pkg::NUM_CHANNELS_DEF;
	localparam int CH_W     = $clog2(NUM_CH);
	localparam int RES_W    = ((CH_W + TIME_W + DUTY_W + 7) / 8) * 8;
	localparam int GAP_PCT  = 6;
	localparam int SETTLE   = 6;      // no-result items still pass through SCAN after transfer
	localparam int WDOG_MAX = 4000;   // idle cycles before the watchdog stops the run

	// one sampled pin byte with its timer stamp, packed as it travels on tdata
	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic [PIN_W-1:0]  pins;
	} pin_sample_t;

	typedef struct packed {
		logic [CH_W-1:0]   chan;
		logic [TIME_W-1:0] width;
		logic [DUTY_W-1:0] duty;
		logic              last;
	} pulse_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     s_axis_tvalid = 1'b0;
	logic                     s_axis_tready;
	// [7:0] pin_levels, [39:8] time_count
	logic [PIN_W+TIME_W-1:0]  s_axis_tdata = '0;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready = 1'b0;
	// [1:0] channel, [33:2] pulse_width, [50:34] duty, rest zero
	logic [RES_W-1:0]         m_axis_tdata;
	logic                     m_axis_tlast;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [TIME_W-1:0]        cfg_wdata = '0;

	rc_pulse_width_capture uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// samples waiting for the driver, pulses waiting for the block
	pin_sample_t sample_q[$];
	pulse_t      pulse_q[$];

	// predictor copy of the register file and the edge state
	logic [PIN_W-1:0]  mask_cfg = rcpwc_pkg::PIN_MASK_RST;
	logic [TIME_W-1:0] max_cfg  = rcpwc_pkg::MAX_WIDTH_RST;
	logic [TIME_W-1:0] min_cfg  = rcpwc_pkg::MIN_WIDTH_RST;
	logic [NUM_CH-1:0] lvl_seen = '0;
	logic [TIME_W-1:0] rise_time [NUM_CH];

	// stimulus generator state
	logic [TIME_W-1:0] gen_stamp = '0;
	int items_queued = 0;
	bit gaps_on = 1'b1;

	int errors = 0;
	int n_items = 0;
	int n_results = 0;
	int n_full = 0;
	int n_zero = 0;
	int n_scaled = 0;
	int n_settings = 1;
	int idle_cycles = 0;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("result error at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
	endtask

	// clamp first on max, then on min; else truncated (w-min)/(max-min) in Q1.16
	function automatic logic [DUTY_W-1:0] width_to_duty(input logic [TIME_W-1:0] w);
		logic [63:0] scaled;
		if (w >= max_cfg)
			return rcpwc_pkg::DUTY_FULL;
		if (w <= min_cfg)
			return rcpwc_pkg::DUTY_ZERO;
		scaled = {32'd0, w - min_cfg} << FRAC_W;
		scaled = scaled / {32'd0, max_cfg - min_cfg};
		return scaled[DUTY_W-1:0];
	endfunction

	// edge detect over the first four masked pins; results in channel order
	task automatic predict_edges(input pin_sample_t s);
		logic [PIN_W-1:0] chan_pin [NUM_CH];
		pulse_t found [NUM_CH];
		bit now_high;
		int i;
		int k;
		int n;
		for (i = 0; i < NUM_CH; i++)
			chan_pin[i] = '0;
		k = 0;
		for (i = 0; i < PIN_W; i++) begin
			if (mask_cfg[i] && k < NUM_CH) begin
				chan_pin[k] = PIN_W'(1) << i;
				k++;
			end
		end
		n = 0;
		for (i = 0; i < NUM_CH; i++) begin
			// a channel with no pin reads low, so a high level there falls
			now_high = |(s.pins & chan_pin[i]);
			if (!lvl_seen[i] && now_high) begin
				rise_time[i] = s.stamp;
				lvl_seen[i] = 1'b1;
			end else if (lvl_seen[i] && !now_high) begin
				lvl_seen[i] = 1'b0;
				found[n].chan = CH_W'(i);
				found[n].width = s.stamp - rise_time[i];
				found[n].duty = width_to_duty(found[n].width);
				found[n].last = 1'b0;
				n++;
			end
		end
		for (i = 0; i < n; i++) begin
			found[i].last = (i == n - 1);
			pulse_q.push_back(found[i]);
		end
	endtask

	// driver: hold a stalled transfer, otherwise load the next sample or idle
	always @(posedge clk) begin
		if (arst_n && !(s_axis_tvalid && !s_axis_tready)) begin
			if (sample_q.size() > 0 && !(gaps_on && $urandom_range(99) < GAP_PCT)) begin
				s_axis_tdata <= sample_q.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
	end

	// input-side monitor feeds the predictor on every accepted transfer
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			n_items++;
			predict_edges(s_axis_tdata);
		end
	end

	// output-side monitor: field by field against the oldest expected pulse
	always @(posedge clk) begin
		pulse_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (pulse_q.size() == 0) begin
				report("unexpected result", 64'(m_axis_tdata), 64'd0);
			end else begin
				want = pulse_q.pop_front();
				if (m_axis_tdata[CH_W-1:0] != want.chan)
					report("channel", 64'(m_axis_tdata[CH_W-1:0]), 64'(want.chan));
				if (m_axis_tdata[CH_W +: TIME_W] != want.width)
					report("pulse_width", 64'(m_axis_tdata[CH_W +: TIME_W]), 64'(want.width));
				if (m_axis_tdata[CH_W+TIME_W +: DUTY_W] != want.duty)
					report("duty", 64'(m_axis_tdata[CH_W+TIME_W +: DUTY_W]), 64'(want.duty));
				if (m_axis_tlast != want.last)
					report("last", 64'(m_axis_tlast), 64'(want.last));
				if (want.duty == rcpwc_pkg::DUTY_FULL)
					n_full++;
				else if (want.duty == rcpwc_pkg::DUTY_ZERO)
					n_zero++;
				else
					n_scaled++;
			end
		end
	end

	// watchdog: any transfer on either side restarts the count
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WDOG_MAX) begin
			$display("watchdog: no transfer for %0d cycles, %0d pulses outstanding",
				WDOG_MAX, pulse_q.size());
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_sample(input logic [PIN_W-1:0] lvl, input logic [TIME_W-1:0] t);
		sample_q.push_back({t, lvl});
		gen_stamp = t;
		items_queued++;
	endtask

	// widths around the current thresholds, plus tiny and full-range ones
	function automatic logic [TIME_W-1:0] pick_width();
		case ($urandom_range(0, 9))
			0: return min_cfg;
			1: return max_cfg;
			2: return min_cfg + 1;
			3: return max_cfg - 1;
			4: return $urandom;
			5: return $urandom_range(0, 3);
			default: begin
				if (max_cfg > min_cfg)
					return min_cfg + $urandom_range(0, max_cfg - min_cfg);
				return $urandom_range(0, 300);
			end
		endcase
	endfunction

	// one receiver frame: a set of pins rises together, each falls after its width;
	// pins with equal widths fall in the same sample. Now and then the frame is cut short.
	task automatic queue_frame();
		logic [PIN_W-1:0]  lvl;
		logic [TIME_W-1:0] hold [PIN_W];
		logic [TIME_W-1:0] t0;
		logic [TIME_W-1:0] soonest;
		int b;
		lvl = PIN_W'($urandom_range(1, 255));
		t0 = gen_stamp + $urandom_range(1, 500);
		for (b = 0; b < PIN_W; b++)
			hold[b] = (b > 0 && $urandom_range(3) == 0) ? hold[0] : pick_width();
		push_sample(lvl, t0);
		while (lvl != '0 && $urandom_range(99) >= 8) begin
			soonest = '1;
			for (b = 0; b < PIN_W; b++)
				if (lvl[b] && hold[b] <= soonest)
					soonest = hold[b];
			for (b = 0; b < PIN_W; b++)
				if (lvl[b] && hold[b] == soonest)
					lvl[b] = 1'b0;
			push_sample(lvl, t0 + soonest);
		end
	endtask

	task automatic queue_random(input int n);
		int target;
		target = items_queued + n;
		while (items_queued < target) begin
			if ($urandom_range(99) < 85)
				queue_frame();
			else if ($urandom_range(9) == 0)
				push_sample(PIN_W'($urandom), $urandom);
			else
				push_sample(PIN_W'($urandom), gen_stamp + $urandom_range(0, 100));
		end
	endtask

	// block idle: all samples taken, all pulses seen, last no-result item finished
	task automatic settle();
		while (sample_q.size() != 0 || s_axis_tvalid || pulse_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			rcpwc_pkg::REG_PIN_MASK:  mask_cfg = val[PIN_W-1:0];
			rcpwc_pkg::REG_MAX_WIDTH: max_cfg = val;
			rcpwc_pkg::REG_MIN_WIDTH: min_cfg = val;
			default: ;
		endcase
	endtask

	task automatic finish_regs();
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	initial begin
		int p;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset thresholds 63..125
		push_sample(8'h0F, 32'hFFFF_FFF0);   // all four rise just before the wrap
		push_sample(8'h0E, 32'h0000_0030);   // ch0 across the wrap, scaled
		push_sample(8'h0C, 32'h0000_006D);   // ch1 exactly max
		push_sample(8'h08, 32'h0000_006E);   // ch2 above max
		push_sample(8'h00, 32'h0000_0070);   // ch3
		push_sample(8'hF0, 32'h0000_0100);   // unused pins only
		push_sample(8'h00, 32'h0000_0200);
		push_sample(8'hFF, 32'h0000_1000);
		push_sample(8'h00, 32'h0000_1000);   // zero width, four results in one item
		push_sample(8'hFF, 32'h0000_0000);
		push_sample(8'h00, 32'hFFFF_FFFF);   // widest possible pulse
		push_sample(8'h05, 32'h0000_2000);
		push_sample(8'h0A, 32'h0000_203F);   // ch0/ch2 fall at min while ch1/ch3 rise
		push_sample(8'h00, 32'h0000_20BC);
		push_sample(8'h01, 32'h0000_3000);
		push_sample(8'h00, 32'h0000_307C);   // one below max
		push_sample(8'h0C, 32'h0000_4000);   // leave ch2/ch3 high for the mask change
		settle();

		// two pins only: ch2/ch3 lose their pins while high and fall on the next sample
		set_reg(rcpwc_pkg::REG_PIN_MASK, 32'h0000_00A0);
		finish_regs();
		push_sample(8'h00, 32'h0000_4050);
		push_sample(8'hA0, 32'h0000_5000);
		push_sample(8'h20, 32'h0000_5060);
		push_sample(8'h00, 32'h0000_5070);
		queue_random(50);
		settle();

		// widest mask and full threshold range
		set_reg(rcpwc_pkg::REG_PIN_MASK, 32'h0000_00FF);
		set_reg(rcpwc_pkg::REG_MAX_WIDTH, 32'hFFFF_FFFF);
		set_reg(rcpwc_pkg::REG_MIN_WIDTH, 32'h0000_0000);
		finish_regs();
		queue_random(60);
		settle();

		// max below min: only the max clamp or zero
		set_reg(rcpwc_pkg::REG_PIN_MASK, 32'h0000_003C);
		set_reg(rcpwc_pkg::REG_MAX_WIDTH, 32'd10);
		set_reg(rcpwc_pkg::REG_MIN_WIDTH, 32'd200);
		finish_regs();
		queue_random(50);
		settle();

		// no pins at all: whatever is high falls, then nothing happens
		set_reg(rcpwc_pkg::REG_PIN_MASK, 32'h0000_0000);
		finish_regs();
		queue_random(20);
		settle();

		// max equal to min
		set_reg(rcpwc_pkg::REG_PIN_MASK, 32'h0000_0081);
		set_reg(rcpwc_pkg::REG_MAX_WIDTH, 32'd300);
		set_reg(rcpwc_pkg::REG_MIN_WIDTH, 32'd300);
		finish_regs();
		queue_random(50);
		settle();

		// back to reset values with no idling on either side
		set_reg(rcpwc_pkg::REG_PIN_MASK, 32'(rcpwc_pkg::PIN_MASK_RST));
		set_reg(rcpwc_pkg::REG_MAX_WIDTH, rcpwc_pkg::MAX_WIDTH_RST);
		set_reg(rcpwc_pkg::REG_MIN_WIDTH, rcpwc_pkg::MIN_WIDTH_RST);
		finish_regs();
		gaps_on = 1'b0;
		queue_random(110);
		settle();
		gaps_on = 1'b1;

		// random settings, mostly small thresholds so the divider gets used
		for (p = 0; p < 4; p++) begin
			set_reg(rcpwc_pkg::REG_PIN_MASK, $urandom_range(0, 255));
			if (p == 3) begin
				set_reg(rcpwc_pkg::REG_MAX_WIDTH, $urandom);
				set_reg(rcpwc_pkg::REG_MIN_WIDTH, $urandom);
			end else begin
				set_reg(rcpwc_pkg::REG_MAX_WIDTH, $urandom_range(0, 400));
				set_reg(rcpwc_pkg::REG_MIN_WIDTH, $urandom_range(0, 400));
			end
			finish_regs();
			queue_random(30);
			settle();
		end

		repeat (20) @(posedge clk);
		$display("covered %0d input transfers, %0d pulse results over %0d register settings",
			n_items, n_results, n_settings);
		$display("duty paths: %0d full scale, %0d zero, %0d divided",
			n_full, n_zero, n_scaled);
		if (errors == 0 && pulse_q.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/rcpwc_pkg.sv
rtl/rcpwc_chan_map.sv
rtl/rcpwc_divider.sv
rtl/rc_pulse_width_capture.sv
verif/tb.sv
